// ===== src/wia_pkg.sv =====
// Shared types and constants for the 128-bit integer ALU.
// Used by wide_integer_alu_128 and its port checker; depends on nothing else.
package wia_pkg;

    localparam int HALF_BITS = 64;

    typedef logic [3:0] t_action;

    // Operation codes.
    localparam t_action ACT_ADD = 4'd0;
    localparam t_action ACT_SUB = 4'd1;
    localparam t_action ACT_MUL = 4'd2;
    localparam t_action ACT_DIV = 4'd3;
    localparam t_action ACT_AND = 4'd4;
    localparam t_action ACT_OR  = 4'd5;
    localparam t_action ACT_XOR = 4'd6;
    localparam t_action ACT_SHL = 4'd7;
    localparam t_action ACT_SHR = 4'd8;
    localparam t_action ACT_NEG = 4'd9;

    // Input word: operation and two operands split into halves.
    typedef struct packed {
        t_action                action;
        logic [HALF_BITS-1:0]   a_low;
        logic [HALF_BITS-1:0]   a_high;
        logic [HALF_BITS-1:0]   b_low;
        logic [HALF_BITS-1:0]   b_high;
    } t_in_word;

    // Output word: result or quotient, remainder and flags.
    typedef struct packed {
        logic [HALF_BITS-1:0]   result_low;
        logic [HALF_BITS-1:0]   result_high;
        logic [HALF_BITS-1:0]   rem_low;
        logic [HALF_BITS-1:0]   rem_high;
        logic                   a_below_b;
        logic                   a_same_b;
        logic                   zero_divisor;
    } t_out_word;

endpackage

// ===== src/wide_integer_alu_128.sv =====
// Top level of the unsigned 128-bit integer ALU with iterative multiply and divide.
// Depends on wia_pkg for the word types and operation codes.

// Unsigned 128-bit ALU. One word is taken at a time; o_in_ready is high only while
// the unit is idle. Add, subtract, negate, logic ops and shifts deliver their result
// into the output register after the compare, execute and done states. Multiply
// (shift-add) and divide (restoring shift-subtract) run one bit per cycle through a
// single shared 129-bit adder; the effective width is capped at 128. A divide by zero
// skips the loop and goes straight from execute to done. A finished result sits in
// the output register until taken, and a new input word may be accepted while it
// waits; the unit is ready again in the same cycle that its result enters the output
// register. If the output register still holds an untaken word when the next result
// is finished, the unit waits for it. The comparison flags are produced for every
// operation; a divide by zero returns zero with zero_divisor set, and a shift by
// WORD_BITS or more returns zero.
module wide_integer_alu_128 #(
    parameter int WORD_BITS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wia_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wia_pkg::t_out_word o_out_word
);
    import wia_pkg::*;

    localparam int EFF    = (WORD_BITS > 128) ? 128 : WORD_BITS;
    localparam int CNT_W  = $clog2(EFF);
    localparam logic [127:0] MASK = {128{1'b1}} >> (128 - EFF);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    t_action          r_op, n_op;
    logic [127:0]     r_a, n_a;
    logic [127:0]     r_b, n_b;
    logic [127:0]     r_acc, n_acc;
    logic [127:0]     r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_lt, n_lt;
    logic             r_eq, n_eq;
    logic             r_zdiv, n_zdiv;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic [128:0]     add_x, add_y, add_sum;
    logic             add_sub;
    logic [128:0]     div_shifted;
    logic             div_take;
    logic             shift_ok;

    assign div_shifted = {r_rem, r_a[EFF-1]};
    assign shift_ok    = (r_b[127:64] == '0) && (r_b[63:0] < 64'(EFF));

    // Shared adder operand selection for compare, add/sub and the bit-serial loops.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_CMP: begin
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            S_EXEC: begin
                case (r_op)
                    ACT_ADD: begin
                        add_x = {1'b0, r_a};
                        add_y = {1'b0, r_b};
                    end
                    ACT_NEG: begin
                        add_y   = {1'b0, r_a};
                        add_sub = 1'b1;
                    end
                    ACT_MUL: begin
                        add_x = {1'b0, r_acc};
                        add_y = r_b[0] ? {1'b0, r_a} : '0;
                    end
                    ACT_DIV: begin
                        add_x   = div_shifted;
                        add_y   = {1'b0, r_b};
                        add_sub = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        add_sum = add_x + (add_y ^ {129{add_sub}}) + 129'(add_sub);
    end

    // A non-negative trial difference means the divisor fits.
    assign div_take = !add_sum[128];

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_lt        = r_lt;
        n_eq        = r_eq;
        n_zdiv      = r_zdiv;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_word.action;
                    n_a     = {i_in_word.a_high, i_in_word.a_low} & MASK;
                    n_b     = {i_in_word.b_high, i_in_word.b_low} & MASK;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // The adder computes a - b here: flags, and the subtract result.
                n_lt    = add_sum[128];
                n_eq    = (add_sum == '0);
                n_acc   = (r_op == ACT_SUB) ? (add_sum[127:0] & MASK) : '0;
                n_rem   = '0;
                n_zdiv  = (r_op == ACT_DIV) && (r_b == '0);
                n_cnt   = CNT_W'(EFF - 1);
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    ACT_ADD, ACT_NEG: begin
                        n_acc = add_sum[127:0] & MASK;
                    end
                    ACT_MUL: begin
                        // One multiplier bit per cycle, multiplicand moves left.
                        if (r_b[0]) begin
                            n_acc = add_sum[127:0] & MASK;
                        end
                        n_a = r_a << 1;
                        n_b = r_b >> 1;
                        if (r_cnt != '0) begin
                            n_cnt   = r_cnt - CNT_W'(1);
                            n_state = S_EXEC;
                        end
                    end
                    ACT_DIV: begin
                        // Dividend bits leave the top of r_a, quotient bits enter below.
                        if (!r_zdiv) begin
                            n_rem = div_take ? add_sum[127:0] : div_shifted[127:0];
                            n_a   = {r_a[126:0], div_take};
                            if (r_cnt != '0) begin
                                n_cnt   = r_cnt - CNT_W'(1);
                                n_state = S_EXEC;
                            end else begin
                                n_acc = {r_a[126:0], div_take} & MASK;
                            end
                        end
                    end
                    ACT_AND: n_acc = r_a & r_b;
                    ACT_OR:  n_acc = r_a | r_b;
                    ACT_XOR: n_acc = r_a ^ r_b;
                    ACT_SHL: begin
                        if (shift_ok) begin
                            n_acc = (r_a << r_b[6:0]) & MASK;
                        end
                    end
                    ACT_SHR: begin
                        if (shift_ok) begin
                            n_acc = r_a >> r_b[6:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out.result_low   = r_acc[63:0];
                    n_out.result_high  = r_acc[127:64];
                    n_out.rem_low      = r_rem[63:0];
                    n_out.rem_high     = r_rem[127:64];
                    n_out.a_below_b    = r_lt;
                    n_out.a_same_b     = r_eq;
                    n_out.zero_divisor = r_zdiv;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_lt   <= n_lt;
        r_eq   <= n_eq;
        r_zdiv <= n_zdiv;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== src/wia_checker.sv =====
// Port-level checker for wide_integer_alu_128, bound to every instance.
// Depends on wia_pkg for the word types.
module wia_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input wia_pkg::t_out_word o_out_word
);
    import wia_pkg::*;

    // A waiting output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped before it was taken");

    // A waiting output word keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // The unit works on one word at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while busy");

    // A divide by zero returns zero quotient and remainder.
    a_zdiv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.zero_divisor |->
            o_out_word.result_low == '0 && o_out_word.result_high == '0 &&
            o_out_word.rem_low == '0 && o_out_word.rem_high == '0)
        else $error("nonzero result on divide by zero");

    // Less-than and equal cannot both hold.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.a_below_b && o_out_word.a_same_b))
        else $error("compare flags contradict");

endmodule

bind wide_integer_alu_128 wia_checker u_wia_checker (.*);
